[src/rle_escape_encoder_crc16_top_macros.svh]
// assertion macros for the run-length encoder checker
`ifndef RLE_ESCAPE_ENCODER_CRC16_TOP_MACROS_SVH
`define RLE_ESCAPE_ENCODER_CRC16_TOP_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define RLEE_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("rlee check failed");

// next-cycle implication, sampled on clk_i, off during reset
`define RLEE_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("rlee check failed");

`endif

[src/rlee_pkg.sv]
// shared types, constants and crc function of the run-length encoder
`timescale 1ns / 1ps
`default_nettype none
package rlee_pkg;

  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [7:0]  RUN_MAX     = 8'd255;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam logic        REG_ESCAPE  = 1'b0;

  typedef struct packed {
    logic [7:0]  run_value;
    logic [7:0]  run_length;
    logic [15:0] crc;
    logic        eos;
  } cmd_t;

  typedef enum logic [1:0] {
    PH_ESC,
    PH_CNT,
    PH_VAL
  } phase_e;

  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0]  x;
    logic [15:0] r;
    x = crc[15:8] ^ b;
    x = x ^ {4'b0000, x[7:4]};
    r = {crc[7:0], 8'h00} ^ {x[3:0], 12'h000} ^ {3'b000, x, 5'b00000} ^ {8'h00, x};
    return r;
  endfunction

endpackage
`default_nettype wire

[src/rlee_front.sv]
// front end: accepts raw bytes, keeps run and crc state, issues run commands
`timescale 1ns / 1ps
`default_nettype none
module rlee_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [7:0]    data_byte_i,
  input  wire logic          last_byte_i,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic          q_full_i,
  output logic               push_o,
  output rlee_pkg::cmd_t     push_cmd_o
);

  logic [7:0]     run_value_q, run_value_d;
  logic [7:0]     run_len_q, run_len_d;
  logic [15:0]    crc_q, crc_d;
  logic           pend_q, pend_d;
  rlee_pkg::cmd_t pend_cmd_q, pend_cmd_d;

  logic           accept;
  logic           extend;
  logic           close;
  logic [15:0]    crc_n;
  logic [7:0]     new_value;
  logic [7:0]     new_len;
  rlee_pkg::cmd_t close_cmd;
  rlee_pkg::cmd_t flush_cmd;

  assign in_ready_o = !pend_q && !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign crc_n      = rlee_pkg::crc_update(crc_q, data_byte_i);
  assign extend     = (run_len_q != 8'd0) && (run_value_q == data_byte_i) &&
                      (run_len_q != rlee_pkg::RUN_MAX);
  assign close      = (run_len_q != 8'd0) && !extend;
  assign new_value  = extend ? run_value_q : data_byte_i;
  assign new_len    = extend ? (run_len_q + 8'd1) : 8'd1;

  always_comb begin
    close_cmd.run_value  = run_value_q;
    close_cmd.run_length = run_len_q;
    close_cmd.crc        = crc_n;
    close_cmd.eos        = 1'b0;
    flush_cmd.run_value  = new_value;
    flush_cmd.run_length = new_len;
    flush_cmd.crc        = crc_n;
    flush_cmd.eos        = 1'b1;
  end

  always_comb begin
    run_value_d = run_value_q;
    run_len_d   = run_len_q;
    crc_d       = crc_q;
    pend_d      = pend_q;
    pend_cmd_d  = pend_cmd_q;
    push_o      = 1'b0;
    push_cmd_o  = close_cmd;
    if (pend_q) begin
      push_cmd_o = pend_cmd_q;
      if (!q_full_i) begin
        push_o = 1'b1;
        pend_d = 1'b0;
      end
    end else if (accept) begin
      if (close) begin
        push_o     = 1'b1;
        push_cmd_o = close_cmd;
        if (last_byte_i) begin
          pend_d     = 1'b1;
          pend_cmd_d = flush_cmd;
        end
      end else if (last_byte_i) begin
        push_o     = 1'b1;
        push_cmd_o = flush_cmd;
      end
      if (last_byte_i) begin
        run_value_d = 8'd0;
        run_len_d   = 8'd0;
        crc_d       = rlee_pkg::CRC_INIT;
      end else begin
        run_value_d = new_value;
        run_len_d   = new_len;
        crc_d       = crc_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_value_q <= 8'd0;
      run_len_q   <= 8'd0;
      crc_q       <= rlee_pkg::CRC_INIT;
      pend_q      <= 1'b0;
    end else begin
      run_value_q <= run_value_d;
      run_len_q   <= run_len_d;
      crc_q       <= crc_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_cmd_q <= pend_cmd_d;
  end

endmodule
`default_nettype wire

[src/rlee_queue.sv]
// short command queue between front end and back end
`timescale 1ns / 1ps
`default_nettype none
module rlee_queue #(
  parameter int unsigned DEPTH = rlee_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire rlee_pkg::cmd_t push_cmd_i,
  input  wire logic           pop_i,
  output rlee_pkg::cmd_t      head_o,
  output logic                head_valid_o,
  output logic                full_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  rlee_pkg::cmd_t entry_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign head_valid_o = (count_q != '0);
  assign full_o       = (count_q == CntW'(DEPTH));
  assign head_o       = entry_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : (wr_ptr_q + PtrW'(1));
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : (rd_ptr_q + PtrW'(1));
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule
`default_nettype wire

[src/rlee_back.sv]
// back end: expands run commands into escape, count, byte beats
`timescale 1ns / 1ps
`default_nettype none
module rlee_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire rlee_pkg::cmd_t cmd_i,
  input  wire logic           cmd_valid_i,
  input  wire logic [7:0]     escape_i,
  output logic                pop_o,
  output logic [7:0]          out_byte_o,
  output logic                end_of_stream_o,
  output logic [15:0]         crc_value_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i
);

  rlee_pkg::phase_e phase_q, phase_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  byte_q, byte_d;
  logic        eos_q, eos_d;
  logic [15:0] crc_q, crc_d;

  logic        load;
  logic        single;
  logic        is_last;
  logic [7:0]  cur_byte;

  assign load   = cmd_valid_i && (!out_valid_q || out_ready_i);
  assign single = (cmd_i.run_value == escape_i) && (cmd_i.run_length == 8'd1);

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (load) begin
      case (phase_q)
        rlee_pkg::PH_ESC: phase_d = rlee_pkg::PH_CNT;
        rlee_pkg::PH_CNT: phase_d = single ? rlee_pkg::PH_ESC : rlee_pkg::PH_VAL;
        rlee_pkg::PH_VAL: phase_d = rlee_pkg::PH_ESC;
        default:          phase_d = rlee_pkg::PH_ESC;
      endcase
    end
  end

  // beat contents per phase
  always_comb begin
    case (phase_q)
      rlee_pkg::PH_ESC: begin
        cur_byte = escape_i;
        is_last  = 1'b0;
      end
      rlee_pkg::PH_CNT: begin
        cur_byte = single ? 8'h00 : cmd_i.run_length;
        is_last  = single;
      end
      rlee_pkg::PH_VAL: begin
        cur_byte = cmd_i.run_value;
        is_last  = 1'b1;
      end
      default: begin
        cur_byte = escape_i;
        is_last  = 1'b0;
      end
    endcase
  end

  assign pop_o = load && is_last;

  always_comb begin
    out_valid_d = out_valid_q;
    byte_d      = byte_q;
    eos_d       = eos_q;
    crc_d       = crc_q;
    if (load) begin
      out_valid_d = 1'b1;
      byte_d      = cur_byte;
      eos_d       = cmd_i.eos && is_last;
      crc_d       = cmd_i.crc;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= rlee_pkg::PH_ESC;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    eos_q  <= eos_d;
    crc_q  <= crc_d;
  end

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = byte_q;
  assign end_of_stream_o = eos_q;
  assign crc_value_o     = crc_q;

endmodule
`default_nettype wire

[src/rle_escape_encoder_crc16_top.sv]
// Run-length encoder with escape byte and running CRC-16. Raw bytes enter one beat per cycle
// while the command queue has room; each closed run leaves as escape, count, byte (a lone
// escape byte as escape, 0x00), one output beat per cycle while out_ready_i is high, so the
// output side sets the sustained rate. An input beat that both closes a run and ends the
// stream holds the input off until its second command is in the queue. Every output beat
// carries the CRC over the stream's raw bytes up to the beat that caused it; end_of_stream
// marks the last beat of a stream. The user must write the escape byte over the APB port,
// at addresses 0 to 3 (paddr[2] clear), only while the block is idle, which is not enforced.
`timescale 1ns / 1ps
`default_nettype none
module rle_escape_encoder_crc16_top #(
  parameter int unsigned QUEUE_DEPTH = rlee_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  output logic [7:0]       out_byte_o,
  output logic             end_of_stream_o,
  output logic [15:0]      crc_value_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [7:0]     escape_q, escape_d;
  logic           cfg_wr;
  logic           push;
  rlee_pkg::cmd_t push_cmd;
  logic           q_full;
  rlee_pkg::cmd_t head;
  logic           head_valid;
  logic           pop;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == rlee_pkg::REG_ESCAPE);

  always_comb begin
    escape_d = escape_q;
    if (cfg_wr) begin
      escape_d = pwdata[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      escape_q <= 8'd0;
    end else begin
      escape_q <= escape_d;
    end
  end

  assign prdata = (paddr[2] == rlee_pkg::REG_ESCAPE) ? {24'd0, escape_q} : 32'd0;

  rlee_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_cmd_o  (push_cmd)
  );

  rlee_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_cmd_i   (push_cmd),
    .pop_i        (pop),
    .head_o       (head),
    .head_valid_o (head_valid),
    .full_o       (q_full)
  );

  rlee_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (head),
    .cmd_valid_i     (head_valid),
    .escape_i        (escape_q),
    .pop_o           (pop),
    .out_byte_o      (out_byte_o),
    .end_of_stream_o (end_of_stream_o),
    .crc_value_o     (crc_value_o),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i)
  );

endmodule
`default_nettype wire

[src/rlee_checker.sv]
// port-level checker for the run-length encoder, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "rle_escape_encoder_crc16_top_macros.svh"
module rlee_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic [7:0]  out_byte_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic        psel,
  input wire logic        penable,
  input wire logic        pwrite,
  input wire logic [2:0]  paddr,
  input wire logic [31:0] pwdata,
  input wire logic [31:0] prdata,
  input wire logic        pready
);

  logic cfg_esc_wr;

  assign cfg_esc_wr = psel && penable && pwrite && !paddr[2];

  `RLEE_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_byte_o))
  `RLEE_ASSERT_IMP(a_pready_high, 1'b1, pready)
  `RLEE_ASSERT_IMP(a_prdata_upper, 1'b1, prdata[31:8] == 24'd0)
  `RLEE_ASSERT_NXT(a_cfg_readback, cfg_esc_wr, paddr[2] || (prdata[7:0] == $past(pwdata[7:0])))

endmodule

bind rle_escape_encoder_crc16_top rlee_checker u_rlee_checker (.*);
`default_nettype wire

[tb/tb.sv]
// self-checking testbench for the run-length escape encoder with running crc-16
`timescale 1ns / 1ps
module tb;

  localparam logic [2:0]  ADDR_ESCAPE      = 3'd0;
  localparam logic [2:0]  ADDR_SPARE       = 3'd4;
  localparam logic [7:0]  LONE_ESCAPE_MARK = 8'h00;
  localparam logic [15:0] CRC_POLY         = 16'h1021;
  localparam int          SETTLE_CYCLES    = 12;
  localparam int          HOLD_OFF_CYCLES  = 300;
  localparam int          WATCHDOG_LIMIT   = 5000;

  typedef struct {
    logic [7:0]  enc_byte;
    logic        eos;
    logic [15:0] crc;
  } beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic [7:0]  data_byte_i = 8'h00;
  logic        last_byte_i = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  out_byte_o;
  logic        end_of_stream_o;
  logic [15:0] crc_value_o;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  rle_escape_encoder_crc16_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .data_byte_i     (data_byte_i),
    .last_byte_i     (last_byte_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .out_byte_o      (out_byte_o),
    .end_of_stream_o (end_of_stream_o),
    .crc_value_o     (crc_value_o),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // encoder model state
  logic [7:0]  esc_model = 8'h00;
  logic [7:0]  run_byte = 8'h00;
  logic [7:0]  run_count = 8'h00;
  logic [15:0] crc_acc = rlee_pkg::CRC_INIT;
  beat_t       pending_beats[$];
  beat_t       exp_beat;

  int errors = 0;
  int bytes_in = 0;
  int beats_out = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int idle_count = 0;
  int hold_left = 0;
  logic hold_off_req = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [15:0] crc_fold(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] acc;
    acc = c ^ {d, 8'h00};
    for (int i = 0; i < 8; i++) begin
      acc = acc[15] ? ((acc << 1) ^ CRC_POLY) : (acc << 1);
    end
    return acc;
  endfunction

  function automatic void push_beat(input logic [7:0] b, input logic eos);
    beat_t nb;
    nb.enc_byte = b;
    nb.eos = eos;
    nb.crc = crc_acc;
    pending_beats.push_back(nb);
  endfunction

  function automatic void close_run(input logic eos_on_end);
    if (run_count != 8'd0) begin
      push_beat(esc_model, 1'b0);
      if (run_byte == esc_model && run_count == 8'd1) begin
        push_beat(LONE_ESCAPE_MARK, eos_on_end);
      end else begin
        push_beat(run_count, 1'b0);
        push_beat(run_byte, eos_on_end);
      end
    end
  endfunction

  function automatic void encode_step(input logic [7:0] d, input logic l);
    crc_acc = crc_fold(crc_acc, d);
    if (run_count != 8'd0 && run_byte == d && run_count < rlee_pkg::RUN_MAX) begin
      run_count = run_count + 8'd1;
    end else begin
      close_run(1'b0);
      run_byte = d;
      run_count = 8'd1;
    end
    if (l) begin
      close_run(1'b1);
      run_byte = 8'h00;
      run_count = 8'h00;
      crc_acc = rlee_pkg::CRC_INIT;
    end
  endfunction

  task automatic send_byte(input logic [7:0] d, input logic l);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= d;
    last_byte_i <= l;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    encode_step(d, l);
    bytes_in++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_ESCAPE) esc_model = value[7:0];
    @(posedge clk_i);
  endtask

  task automatic apb_check_escape();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_ESCAPE;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[7:0] !== esc_model) begin
      $error("escape_byte: expected %h, got %h", esc_model, prdata[7:0]);
      errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_random_stream(input int n);
    int sent;
    int len;
    int pick;
    logic [7:0] b;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(9);
      if (pick == 0) b = esc_model;
      else if (pick == 1) b = 8'h00;
      else if (pick == 2) b = 8'hFF;
      else b = 8'($urandom_range(255));
      len = ($urandom_range(2) == 0) ? $urandom_range(2, 7) : 1;
      for (int k = 0; k < len; k++) begin
        send_byte(b, $urandom_range(11) == 0);
        sent++;
      end
    end
  endtask

  task automatic test_register_access();
    apb_check_escape();
    apb_write(ADDR_ESCAPE, 32'h0000_0000);
    apb_check_escape();
    apb_write(ADDR_SPARE, 32'h0000_005A);
    apb_check_escape();
    send_byte(8'h5A, 1'b1);
    wait_idle();
  endtask

  task automatic test_directed_cases();
    // escape 0x00: lone escape, escape run, top byte, six beats from one input
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h12, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    wait_idle();
    apb_write(ADDR_ESCAPE, 32'h0000_00FF);
    apb_check_escape();
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'h00, 1'b1);
    wait_idle();
  endtask

  task automatic test_escape_change();
    apb_write(ADDR_ESCAPE, 32'h0000_0010);
    send_byte(8'h33, 1'b0);
    send_byte(8'h33, 1'b0);
    send_byte(8'h33, 1'b0);
    wait_idle();
    apb_write(ADDR_ESCAPE, 32'h0000_00EE);
    send_byte(8'h33, 1'b1);
    send_byte(8'hEE, 1'b0);
    wait_idle();
    apb_write(ADDR_ESCAPE, 32'h0000_0020);
    send_byte(8'h55, 1'b1);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    tx_idle_pct = 26;
    rx_idle_pct = 71;
    apb_write(ADDR_ESCAPE, 32'h0000_00FF);
    send_random_stream(52);
    wait_idle();
    tx_idle_pct = 71;
    rx_idle_pct = 26;
    apb_write(ADDR_ESCAPE, $urandom_range(1, 254));
    apb_check_escape();
    send_random_stream(52);
    wait_idle();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    apb_write(ADDR_ESCAPE, 32'h0000_0000);
    send_random_stream(51);
    wait_idle();
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    apb_write(ADDR_ESCAPE, $urandom_range(255));
    hold_off_req = 1'b1;
    for (int i = 0; i < 40; i++) send_byte(8'($urandom_range(255)), i == 39);
    wait_idle();
  endtask

  // receiver side ready with random idling and long hold-off
  always @(posedge clk_i) begin
    if (hold_off_req) begin
      hold_off_req = 1'b0;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // output beat checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      beats_out++;
      if (pending_beats.size() == 0) begin
        $error("unexpected beat: out_byte %h", out_byte_o);
        errors++;
      end else begin
        exp_beat = pending_beats.pop_front();
        if (out_byte_o !== exp_beat.enc_byte) begin
          $error("out_byte: expected %h, got %h", exp_beat.enc_byte, out_byte_o);
          errors++;
        end
        if (end_of_stream_o !== exp_beat.eos) begin
          $error("end_of_stream: expected %b, got %b", exp_beat.eos, end_of_stream_o);
          errors++;
        end
        if (crc_value_o !== exp_beat.crc) begin
          $error("crc_value: expected %h, got %h", exp_beat.crc, crc_value_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (psel && penable && pready)) begin
      idle_count = 0;
    end else begin
      idle_count++;
    end
    if (idle_count >= WATCHDOG_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_register_access();
    test_directed_cases();
    test_escape_change();
    test_random_traffic();
    test_backpressure();
    $display("covered %0d input beats and %0d output beats: lone and repeated escapes,",
             bytes_in, beats_out);
    $display("escape changes mid-run, ignored register, random stalls and a long hold-off");
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/rlee_pkg.sv
src/rlee_front.sv
src/rlee_queue.sv
src/rlee_back.sv
src/rle_escape_encoder_crc16_top.sv
src/rlee_checker.sv
tb/tb.sv
